// ----- hw/rtl/tbo_pkg.sv -----
package tbo_pkg;

    // register indexes of the configuration port
    localparam int unsigned CfgIdxW = 3;
    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_cfg_idx;

endpackage

// ----- hw/rtl/tbo_front.sv -----
// Front end: takes one triangle beat per cycle unless stalled, recentres it on the box
// (doubled coordinates, exact) and forms edges and half sizes.
module tbo_front import tbo_pkg::*; #(
    parameter int CW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [CW-1:0]     i_vert [9],
    input  logic signed [CW-1:0]     i_box_lo [3],
    input  logic signed [CW-1:0]     i_box_hi [3],
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [CW+2:0]     o_v [3][3],
    output logic signed [CW+3:0]     o_e [3][3],
    output logic signed [CW:0]       o_h [3]
);
    logic r_valid;
    logic signed [CW+2:0] r_v [3][3];
    logic signed [CW:0]   r_h [3];
    logic advance;

    assign advance = !r_valid || !i_stall;
    assign o_stall = !advance;
    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_h     = r_h;

    // edges from the registered vertices
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int a = 0; a < 3; a++)
                o_e[i][a] = (CW+4)'(r_v[(i+1)%3][a]) - (CW+4)'(r_v[i][a]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
        if (advance && i_valid) begin
            for (int a = 0; a < 3; a++) begin
                r_h[a] <= (CW+1)'(i_box_hi[a]) - (CW+1)'(i_box_lo[a]);
                for (int i = 0; i < 3; i++)
                    r_v[i][a] <= ((CW+3)'(i_vert[i*3+a]) <<< 1)
                               - (CW+3)'(i_box_lo[a]) - (CW+3)'(i_box_hi[a]);
            end
        end
    end
endmodule

// ----- hw/rtl/tbo_back.sv -----
// Back end: three-stage pipeline of the separating-axis tests.
// Stage 1 products, stage 2 extremes and plane sums, stage 3 decision.
module tbo_back import tbo_pkg::*; #(
    parameter int CW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [CW+2:0]     i_v [3][3],
    input  logic signed [CW+3:0]     i_e [3][3],
    input  logic signed [CW:0]       i_h [3],
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_overlap
);
    localparam int PW = 2*CW + 9;   // edge projections and radii
    localparam int NW = 2*CW + 9;   // normal components
    localparam int DW = 3*CW + 14;  // plane distances

    logic [2:0] r_vld;
    logic advance;
    assign advance = !r_vld[2] || !i_stall;
    assign o_stall = !advance;
    assign o_valid = r_vld[2];

    // stage 1: all products
    logic signed [PW-1:0] r_p [9][3];
    logic signed [PW-1:0] r_rad [9];
    logic signed [NW-1:0] r_n [3];
    logic signed [CW+2:0] r_v1 [3][3];
    logic signed [CW:0]   r_h1 [3];

    // stage 2: extremes and plane dot products
    logic                 r_sep2;
    logic signed [DW-1:0] r_dmin, r_dmax;
    logic r_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                for (int a = 0; a < 3; a++) begin
                    logic signed [CW+3:0] ew, eu, aw, au;
                    ew = i_e[i][(a+2)%3];
                    eu = i_e[i][(a+1)%3];
                    aw = ew[CW+3] ? -ew : ew;
                    au = eu[CW+3] ? -eu : eu;
                    for (int k = 0; k < 3; k++)
                        r_p[i*3+a][k] <= PW'(ew * i_v[k][(a+1)%3])
                                       - PW'(eu * i_v[k][(a+2)%3]);
                    // radius: |e[w]| * h[u] + |e[u]| * h[w]
                    r_rad[i*3+a] <= PW'($signed({1'b0, aw}) * i_h[(a+1)%3])
                                  + PW'($signed({1'b0, au}) * i_h[(a+2)%3]);
                end
            end
            for (int a = 0; a < 3; a++)
                r_n[a] <= NW'(i_e[0][(a+1)%3] * i_e[1][(a+2)%3])
                        - NW'(i_e[0][(a+2)%3] * i_e[1][(a+1)%3]);
            r_v1 <= i_v;
            r_h1 <= i_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            logic sep;
            logic signed [PW-1:0] lo, hi;
            logic signed [CW+2:0] mn, mx;
            logic signed [CW+3:0] vmin, vmax;
            logic signed [DW-1:0] smin, smax;
            sep  = 1'b0;
            smin = '0;
            smax = '0;
            for (int t = 0; t < 9; t++) begin
                lo = r_p[t][0];
                hi = r_p[t][0];
                for (int k = 1; k < 3; k++) begin
                    if (r_p[t][k] < lo) lo = r_p[t][k];
                    if (r_p[t][k] > hi) hi = r_p[t][k];
                end
                if (lo > r_rad[t] || hi < -r_rad[t]) sep = 1'b1;
            end
            for (int a = 0; a < 3; a++) begin
                mn = r_v1[0][a];
                mx = r_v1[0][a];
                for (int k = 1; k < 3; k++) begin
                    if (r_v1[k][a] < mn) mn = r_v1[k][a];
                    if (r_v1[k][a] > mx) mx = r_v1[k][a];
                end
                if ((CW+4)'(mn) > (CW+4)'(r_h1[a]) || (CW+4)'(mx) < -(CW+4)'(r_h1[a]))
                    sep = 1'b1;
                if (r_n[a] > 0) begin
                    vmin = -(CW+4)'(r_h1[a]) - (CW+4)'(r_v1[0][a]);
                    vmax =  (CW+4)'(r_h1[a]) - (CW+4)'(r_v1[0][a]);
                end else begin
                    vmin =  (CW+4)'(r_h1[a]) - (CW+4)'(r_v1[0][a]);
                    vmax = -(CW+4)'(r_h1[a]) - (CW+4)'(r_v1[0][a]);
                end
                smin = smin + DW'(r_n[a] * vmin);
                smax = smax + DW'(r_n[a] * vmax);
            end
            r_sep2 <= sep;
            r_dmin <= smin;
            r_dmax <= smax;
        end
    end

    // stage 3: decision
    always_ff @(posedge i_clk) begin
        if (advance)
            r_ovl <= !r_sep2 && !(r_dmin > 0) && !(r_dmax < 0);
    end
    assign o_overlap = r_ovl;
endmodule

// ----- hw/rtl/triangle_box_overlap.sv -----
// Channel | handshake          | payload
// in      | i_valid / o_stall  | i_vert0_x .. i_vert2_z
// out     | o_valid / i_stall  | o_overlap
// cfg     | i_cfg_we           | i_cfg_idx, i_cfg_data
// One triangle per cycle unless stalled; the result passes the front register
// and then three back stages, fully pipelined.
// Synchronous active-low reset clears valid flags and box registers.
// Output stall freezes the whole pipe while a result waits at the output;
// the front takes a beat whenever its register is empty or moving on.
module triangle_box_overlap import tbo_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CfgIdxW-1:0]           i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]       i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vert0_x, i_vert0_y, i_vert0_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert1_x, i_vert1_y, i_vert1_z,
    input  logic signed [COORD_WIDTH-1:0] i_vert2_x, i_vert2_y, i_vert2_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_overlap
);
    localparam int CW = COORD_WIDTH;
    logic signed [CW-1:0] r_lo [3];
    logic signed [CW-1:0] r_hi [3];
    logic signed [CW-1:0] vert [9];
    logic signed [CW+2:0] v [3][3];
    logic signed [CW+3:0] e [3][3];
    logic signed [CW:0]   h [3];
    logic mid_valid, mid_stall;

    // box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '{default: '0};
            r_hi <= '{default: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_X: r_lo[0] <= i_cfg_data;
                REG_MIN_Y: r_lo[1] <= i_cfg_data;
                REG_MIN_Z: r_lo[2] <= i_cfg_data;
                REG_MAX_X: r_hi[0] <= i_cfg_data;
                REG_MAX_Y: r_hi[1] <= i_cfg_data;
                REG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign vert = '{i_vert0_x, i_vert0_y, i_vert0_z, i_vert1_x, i_vert1_y,
                    i_vert1_z, i_vert2_x, i_vert2_y, i_vert2_z};

    tbo_front #(.CW(CW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_vert(vert), .i_box_lo(r_lo), .i_box_hi(r_hi),
        .o_valid(mid_valid), .i_stall(mid_stall),
        .o_v(v), .o_e(e), .o_h(h)
    );

    tbo_back #(.CW(CW)) u_back (
        .i_clk, .i_rst_n, .i_valid(mid_valid), .o_stall(mid_stall),
        .i_v(v), .i_e(e), .i_h(h),
        .o_valid, .i_stall, .o_overlap
    );
endmodule
